>>> rtl/core/tcr_pkg.sv
// Shared types, codes and constants of the text column renderer.
`default_nettype none
package tcr_pkg;

	// Font store depth in bytes and visible panel width in columns
	localparam int FONT_DEPTH    = 512;
	localparam int PANEL_COLUMNS = 128;

	// Font store address width
	localparam int FA_W = $clog2(FONT_DEPTH);

	// Unreduced glyph base: code offset (8 bits) times width (at most 8)
	localparam int MAX_WIDTH = 8;
	localparam int BASE_W    = 11;
	localparam int BASE_SPAN = 1 << BASE_W;
	localparam int RED_W     = BASE_W + 2;

	// Restoring reduction of the base modulo FONT_DEPTH: one shifted depth per step
	localparam int RED_STEPS = $clog2((BASE_SPAN + FONT_DEPTH - 1) / FONT_DEPTH);
	localparam int RJ_W      = $clog2(RED_STEPS + 2);

	// Background and space columns in inverted video
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_PRINT    = 2'd0,
		OP_PRINT_AT = 2'd1,
		OP_LOAD     = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_GLYPH_WIDTH = 2'd0,
		REG_GLYPH_GAP   = 2'd1,
		REG_FIRST_CODE  = 2'd2
	} reg_idx_t;

	// One column write toward the panel
	typedef struct packed {
		logic       right_half;
		logic [2:0] page;
		logic [5:0] column;
		logic [7:0] pixels;
	} col_item_t;

	// Sequencer to output stage
	typedef struct packed {
		logic      push;
		logic      finish;
		col_item_t item;
	} emit_ctl_t;

	// Output stage to sequencer
	typedef struct packed {
		logic can_push;
		logic fin_ok;
	} emit_sts_t;

	// Font store access
	typedef struct packed {
		logic            we;
		logic [FA_W-1:0] waddr;
		logic [7:0]      wdata;
		logic            re;
		logic [FA_W-1:0] raddr;
	} ram_req_t;

endpackage
`default_nettype wire

>>> rtl/core/tcr_ram.sv
// Generic single write, single registered read port RAM.
`default_nettype none
module tcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tcr_emit.sv
// Output stage: one held column write plus the output register, marks the last item.
`default_nettype none
module tcr_emit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tcr_pkg::emit_ctl_t  ctl,
	output tcr_pkg::emit_sts_t       sts,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     right_half,
	output logic [2:0]               page,
	output logic [5:0]               column,
	output logic [7:0]               pixels,
	output logic                     last
);

	logic               hold_v_q;
	tcr_pkg::col_item_t hold_q;
	logic               out_v_q;
	tcr_pkg::col_item_t out_q;
	logic               last_q;
	logic               out_free;

	// The held item moves out once the next one arrives or the character ends
	assign out_free     = !out_v_q || out_ready;
	assign sts.can_push = !hold_v_q || out_free;
	assign sts.fin_ok   = !hold_v_q || out_free;

	// Control: valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.push) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end else if (out_ready) begin
					out_v_q <= 1'b0;
				end
			end else if (ctl.finish && hold_v_q && out_free) begin
				hold_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			hold_q <= ctl.item;
			if (hold_v_q) begin
				out_q  <= hold_q;
				last_q <= 1'b0;
			end
		end else if (ctl.finish && hold_v_q && out_free) begin
			out_q  <= hold_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid  = out_v_q;
	assign right_half = out_q.right_half;
	assign page       = out_q.page;
	assign column     = out_q.column;
	assign pixels     = out_q.pixels;
	assign last       = last_q;

endmodule
`default_nettype wire

>>> rtl/core/tcr_seq.sv
// Sequencer: cursor, configuration registers, base reduction and column walk.
`default_nettype none
module tcr_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          op,
	input  wire logic [7:0]          char_code,
	input  wire logic                normal_video,
	input  wire logic [2:0]          start_page,
	input  wire logic [6:0]          start_column,
	input  wire logic [8:0]          store_addr,
	input  wire logic [7:0]          store_byte,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	output tcr_pkg::ram_req_t        ram_req,
	input  wire logic [7:0]          ram_rdata,
	output tcr_pkg::emit_ctl_t       ctl,
	input  wire tcr_pkg::emit_sts_t  sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_FILL,
		S_REDUCE,
		S_RD,
		S_WR,
		S_GAP,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [3:0]                    gw_q;
	logic [2:0]                    gg_q;
	logic [7:0]                    first_q;
	logic [2:0]                    page_q;
	logic [7:0]                    col_q;
	logic [3:0]                    width_q;
	logic [2:0]                    gap_q;
	logic [3:0]                    gidx_q;
	logic [tcr_pkg::BASE_W-1:0]    base_q;
	logic [tcr_pkg::FA_W-1:0]      addr_q;
	logic                          normal_q;
	logic [tcr_pkg::RJ_W-1:0]      rj_q;

	logic                          accept;
	logic [3:0]                    width_in;
	logic [7:0]                    code_off;
	logic [tcr_pkg::BASE_W-1:0]    base_in;
	logic                          in_range;
	logic [7:0]                    col_inc;
	logic                          wraps;
	logic [tcr_pkg::RED_W-1:0]     red_sub;
	logic                          push_req;
	logic                          step_ok;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Effective width, code offset and glyph base
	assign width_in = (gw_q > 4'(tcr_pkg::MAX_WIDTH)) ? 4'(tcr_pkg::MAX_WIDTH) : gw_q;
	assign code_off = char_code - first_q;
	assign base_in  = tcr_pkg::BASE_W'(code_off) * tcr_pkg::BASE_W'(width_in);

	// Cursor arithmetic
	assign in_range = col_q < 8'(tcr_pkg::PANEL_COLUMNS);
	assign col_inc  = (col_q == 8'hFF) ? col_q : col_q + 8'd1;
	assign wraps    = ({1'b0, col_q} + 9'(width_q)) > 9'(tcr_pkg::PANEL_COLUMNS - 1);

	// Shifted depth for the current reduction step
	assign red_sub = tcr_pkg::RED_W'(tcr_pkg::FONT_DEPTH) << (rj_q - tcr_pkg::RJ_W'(1));

	// Font store port
	always_comb begin
		ram_req.we    = accept && (tcr_pkg::op_t'(op) == tcr_pkg::OP_LOAD) &&
			(13'(store_addr) < 13'(tcr_pkg::FONT_DEPTH));
		ram_req.waddr = tcr_pkg::FA_W'(store_addr);
		ram_req.wdata = store_byte;
		ram_req.re    = (state_q == S_RD);
		ram_req.raddr = addr_q;
	end

	// Column writes toward the output stage
	always_comb begin
		push_req             = 1'b0;
		ctl.item.right_half  = col_q[6];
		ctl.item.page        = page_q;
		ctl.item.column      = col_q[5:0];
		ctl.item.pixels      = tcr_pkg::FILL_BYTE;
		case (state_q)
			S_FILL: push_req = in_range;
			S_WR: begin
				push_req        = in_range;
				ctl.item.pixels = normal_q ? ram_rdata : ~ram_rdata;
			end
			S_GAP: push_req = !normal_q && (gap_q != 3'd0) && in_range;
			default: push_req = 1'b0;
		endcase
		step_ok    = !push_req || sts.can_push;
		ctl.push   = push_req && sts.can_push;
		ctl.finish = (state_q == S_DONE);
	end

	// Sequencer and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			gw_q     <= 4'd5;
			gg_q     <= 3'd0;
			first_q  <= 8'd32;
			page_q   <= 3'd0;
			col_q    <= 8'd0;
			width_q  <= 4'd0;
			gap_q    <= 3'd0;
			gidx_q   <= 4'd0;
			base_q   <= '0;
			addr_q   <= '0;
			normal_q <= 1'b1;
			rj_q     <= '0;
		end else begin
			// Configuration writes
			if (cfg_we) begin
				case (tcr_pkg::reg_idx_t'(cfg_index))
					tcr_pkg::REG_GLYPH_WIDTH: gw_q    <= cfg_data[3:0];
					tcr_pkg::REG_GLYPH_GAP:   gg_q    <= cfg_data[2:0];
					tcr_pkg::REG_FIRST_CODE:  first_q <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (tcr_pkg::op_t'(op))
							tcr_pkg::OP_PRINT, tcr_pkg::OP_PRINT_AT: begin
								if (tcr_pkg::op_t'(op) == tcr_pkg::OP_PRINT_AT) begin
									page_q <= start_page;
									col_q  <= {1'b0, start_column};
								end
								width_q  <= width_in;
								gap_q    <= gg_q;
								base_q   <= base_in;
								normal_q <= normal_video;
								rj_q     <= tcr_pkg::RJ_W'(tcr_pkg::RED_STEPS);
								state_q  <= S_WRAP;
							end
							default: ;
						endcase
					end
				end
				// Glyph would pass the last column: wrap, filling first in inverted video
				S_WRAP: begin
					if (wraps) begin
						if (!normal_q) begin
							state_q <= S_FILL;
						end else begin
							col_q   <= 8'd0;
							page_q  <= page_q + 3'd1;
							state_q <= S_REDUCE;
						end
					end else begin
						state_q <= S_REDUCE;
					end
				end
				S_FILL: begin
					if (!in_range) begin
						col_q   <= 8'd0;
						page_q  <= page_q + 3'd1;
						state_q <= S_REDUCE;
					end else if (step_ok) begin
						col_q <= col_inc;
					end
				end
				// One compare and subtract per step brings the base below the depth
				S_REDUCE: begin
					if (rj_q == '0) begin
						addr_q <= tcr_pkg::FA_W'(base_q);
						gidx_q <= 4'd0;
						state_q <= (width_q == 4'd0) ? S_GAP : S_RD;
					end else begin
						if (tcr_pkg::RED_W'(base_q) >= red_sub) begin
							base_q <= tcr_pkg::BASE_W'(tcr_pkg::RED_W'(base_q) - red_sub);
						end
						rj_q <= rj_q - tcr_pkg::RJ_W'(1);
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (step_ok) begin
						col_q  <= col_inc;
						addr_q <= (addr_q == tcr_pkg::FA_W'(tcr_pkg::FONT_DEPTH - 1)) ?
							'0 : addr_q + tcr_pkg::FA_W'(1);
						gidx_q <= gidx_q + 4'd1;
						state_q <= (gidx_q + 4'd1 == width_q) ? S_GAP : S_RD;
					end
				end
				S_GAP: begin
					if (gap_q == 3'd0) begin
						state_q <= S_DONE;
					end else if (step_ok) begin
						col_q <= col_inc;
						gap_q <= gap_q - 3'd1;
					end
				end
				S_DONE: begin
					if (sts.fin_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/text_column_renderer.sv
// Top level of the text column renderer: sequencer, font store and output stage.
// Load (op 2) or unused op: input stays ready. Print: busy through the wrap check, any
// inverted fill columns, the base reduction, a read and a write state per glyph column,
// the gap columns and the finish of the character.
// Back-pressure stalls the walk once one column write waits held and one sits out.
// Reset (arst_n low) resets cursor, registers, valid flags at once; font store is not cleared.
`default_nettype none
module text_column_renderer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire logic [7:0] char_code,
	input  wire logic       normal_video,
	input  wire logic [2:0] start_page,
	input  wire logic [6:0] start_column,
	input  wire logic [8:0] store_addr,
	input  wire logic [7:0] store_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            right_half,
	output logic [2:0]      page,
	output logic [5:0]      column,
	output logic [7:0]      pixels,
	output logic            last,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	tcr_pkg::ram_req_t  ram_req;
	logic [7:0]         ram_rdata;
	tcr_pkg::emit_ctl_t ctl;
	tcr_pkg::emit_sts_t sts;

	tcr_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.char_code    (char_code),
		.normal_video (normal_video),
		.start_page   (start_page),
		.start_column (start_column),
		.store_addr   (store_addr),
		.store_byte   (store_byte),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.ctl          (ctl),
		.sts          (sts)
	);

	// Font store
	tcr_ram #(
		.WIDTH (8),
		.DEPTH (tcr_pkg::FONT_DEPTH)
	) u_font (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	tcr_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.right_half (right_half),
		.page       (page),
		.column     (column),
		.pixels     (pixels),
		.last       (last)
	);

endmodule
`default_nettype wire

>>> rtl/core/tcr_checker.sv
// Port-level assertions for the text column renderer and their bind.
`default_nettype none
module tcr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] op,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       right_half,
	input wire logic [2:0] page,
	input wire logic [5:0] column,
	input wire logic [7:0] pixels,
	input wire logic       last
);

	// A stalled column write holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixels) && $stable(column) &&
			$stable(page) && $stable(right_half) && $stable(last))
		else $error("stalled output item changed");

	// A print keeps the input side busy in the following cycle
	a_print_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == tcr_pkg::OP_PRINT || op == tcr_pkg::OP_PRINT_AT)
			|=> !in_ready)
		else $error("ready right after a print item");

	// A font load or unused op returns to ready at once
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !(op == tcr_pkg::OP_PRINT || op == tcr_pkg::OP_PRINT_AT)
			|=> in_ready)
		else $error("not ready after a load item");

	// No column write appears from an item that causes none
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !(op == tcr_pkg::OP_PRINT || op == tcr_pkg::OP_PRINT_AT)
			|=> !$rose(out_valid))
		else $error("output item after a load item");

endmodule

bind text_column_renderer tcr_checker u_tcr_checker (.*);
`default_nettype wire

>>> sim/text_column_renderer_tb.sv
// Self-checking testbench of the text column renderer: random items under back-pressure vs. a predictor.
`default_nettype none
module text_column_renderer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int DRAIN_CYCLES   = 300;   // longest print with a full inverted fill, with margin
	localparam int LONG_STALL     = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HALF_COLUMNS   = tcr_pkg::PANEL_COLUMNS / 2;

	// Codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] REG_NONE  = 2'd3;

	typedef struct {
		logic [1:0] op;
		logic [7:0] code;
		logic       normal;
		logic [2:0] page;
		logic [6:0] col;
		logic [8:0] addr;
		logic [7:0] data;
	} text_item_t;

	typedef struct {
		logic       right_half;
		logic [2:0] page;
		logic [5:0] column;
		logic [7:0] pixels;
		logic       last;
	} col_write_t;

	// DUT signals
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_ready;
	logic [1:0] op           = '0;
	logic [7:0] char_code    = '0;
	logic       normal_video = 1'b0;
	logic [2:0] start_page   = '0;
	logic [6:0] start_column = '0;
	logic [8:0] store_addr   = '0;
	logic [7:0] store_byte   = '0;
	logic       out_valid;
	logic       out_ready    = 1'b0;
	logic       right_half;
	logic [2:0] page;
	logic [5:0] column;
	logic [7:0] pixels;
	logic       last;
	logic       cfg_we       = 1'b0;
	logic [1:0] cfg_index    = '0;
	logic [7:0] cfg_data     = '0;

	// Predictor state: registers, cursor, font image
	logic [3:0] reg_width;
	logic [2:0] reg_gap;
	logic [7:0] reg_first;
	logic [2:0] cur_page;
	logic [7:0] cur_col;
	logic [7:0] font_img [0:tcr_pkg::FONT_DEPTH-1];
	bit         font_loaded [0:tcr_pkg::FONT_DEPTH-1];

	text_item_t pending_items [$];
	col_write_t char_writes [$];
	col_write_t expected_writes [$];
	col_write_t want_wr;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  queued        = 0;
	int  mismatches    = 0;
	int  quiet_cycles  = 0;
	int  stall_cycles  = 0;
	bit  stall_req     = 1'b0;
	bit  stall_done    = 1'b0;
	bit  in_took       = 1'b0;

	text_column_renderer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.char_code   (char_code),
		.normal_video(normal_video),
		.start_page  (start_page),
		.start_column(start_column),
		.store_addr  (store_addr),
		.store_byte  (store_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.right_half  (right_half),
		.page        (page),
		.column      (column),
		.pixels      (pixels),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Cursor moves one column, saturating
	function automatic void step_col();
		if (cur_col != 8'hFF)
			cur_col = cur_col + 8'd1;
	endfunction

	// One column at the cursor; off-panel columns are dropped
	function automatic void put_col(input logic [7:0] px);
		col_write_t wr;
		if (cur_col < tcr_pkg::PANEL_COLUMNS) begin
			wr.right_half = (cur_col >= HALF_COLUMNS);
			wr.page       = cur_page;
			wr.column     = cur_col[5:0];
			wr.pixels     = px;
			wr.last       = 1'b0;
			char_writes.push_back(wr);
		end
		step_col();
	endfunction

	function automatic int unsigned glyph_cols();
		return (reg_width > tcr_pkg::MAX_WIDTH) ? tcr_pkg::MAX_WIDTH : reg_width;
	endfunction

	// Column writes caused by one accepted item
	task automatic render_item(input text_item_t it);
		int unsigned w;
		int unsigned base;
		int unsigned i;
		logic [7:0]  offset;
		logic [7:0]  glyph;
		char_writes.delete();
		if (it.op == tcr_pkg::OP_LOAD) begin
			if (int'(it.addr) < tcr_pkg::FONT_DEPTH)
				font_img[it.addr] = it.data;
			return;
		end
		if (it.op == OP_UNUSED)
			return;
		if (it.op == tcr_pkg::OP_PRINT_AT) begin
			cur_page = it.page;
			cur_col  = {1'b0, it.col};
		end
		w = glyph_cols();
		// Wrap to next page when the glyph does not fit
		if (cur_col + w > tcr_pkg::PANEL_COLUMNS - 1) begin
			if (!it.normal) begin
				while (cur_col < tcr_pkg::PANEL_COLUMNS)
					put_col(tcr_pkg::FILL_BYTE);
			end
			cur_col  = 8'd0;
			cur_page = cur_page + 3'd1;
		end
		offset = it.code - reg_first;
		base   = offset * w;
		for (i = 0; i < w; i++) begin
			glyph = font_img[9'((base + i) % tcr_pkg::FONT_DEPTH)];
			put_col(it.normal ? glyph : ~glyph);
		end
		// Gap columns: filled in inverted video, skipped otherwise
		for (i = 0; i < reg_gap; i++) begin
			if (it.normal)
				step_col();
			else
				put_col(tcr_pkg::FILL_BYTE);
		end
		if (char_writes.size() != 0)
			char_writes[$].last = 1'b1;
		foreach (char_writes[k])
			expected_writes.push_back(char_writes[k]);
	endtask

	// Stimulus building
	task automatic queue_item(input logic [1:0] i_op, input logic [7:0] i_code,
			input logic i_normal, input logic [2:0] i_page, input logic [6:0] i_col,
			input logic [8:0] i_addr, input logic [7:0] i_data);
		text_item_t it;
		it = '{i_op, i_code, i_normal, i_page, i_col, i_addr, i_data};
		pending_items.push_back(it);
		queued++;
	endtask

	task automatic queue_load(input logic [8:0] addr, input logic [7:0] data);
		font_loaded[addr] = 1'b1;
		queue_item(tcr_pkg::OP_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)),
			3'($urandom_range(7)), 7'($urandom_range(127)), addr, data);
	endtask

	// Loads any font byte the glyph still lacks, then the print itself
	task automatic queue_print(input logic [1:0] p_op, input logic [7:0] p_code,
			input logic p_normal, input logic [2:0] p_page, input logic [6:0] p_col);
		int unsigned w;
		int unsigned base;
		int unsigned addr;
		int unsigned i;
		logic [7:0]  offset;
		w      = glyph_cols();
		offset = p_code - reg_first;
		base   = offset * w;
		for (i = 0; i < w; i++) begin
			addr = (base + i) % tcr_pkg::FONT_DEPTH;
			if (!font_loaded[addr[8:0]])
				queue_load(addr[8:0], 8'($urandom_range(255)));
		end
		queue_item(p_op, p_code, p_normal, p_page, p_col,
			9'($urandom_range(tcr_pkg::FONT_DEPTH - 1)), 8'($urandom_range(255)));
	endtask

	task automatic random_items(input int count);
		int         target;
		int         sel;
		logic [7:0] code;
		logic [1:0] print_op;
		target = queued + count;
		while (queued < target) begin
			sel = $urandom_range(99);
			if (sel < 6) begin
				queue_item(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
					3'($urandom_range(7)), 7'($urandom_range(127)),
					9'($urandom_range(tcr_pkg::FONT_DEPTH - 1)), 8'($urandom_range(255)));
			end else if (sel < 22) begin
				queue_load(9'($urandom_range(tcr_pkg::FONT_DEPTH - 1)),
					8'($urandom_range(255)));
			end else begin
				// Mostly a small character set, so the font image fills quickly
				if ($urandom_range(99) < 90)
					code = reg_first + 8'($urandom_range(7));
				else
					code = 8'($urandom_range(255));
				print_op = (sel < 62) ? tcr_pkg::OP_PRINT : tcr_pkg::OP_PRINT_AT;
				queue_print(print_op, code, 1'($urandom_range(1)), 3'($urandom_range(7)),
					7'($urandom_range(127)));
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tcr_pkg::REG_GLYPH_WIDTH: reg_width = value[3:0];
			tcr_pkg::REG_GLYPH_GAP:   reg_gap   = value[2:0];
			tcr_pkg::REG_FIRST_CODE:  reg_first = value;
			default: ;
		endcase
	endtask

	// Wait until every item is in and every column write is out, then let the block settle
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input side: accepted item goes to the predictor
	always @(posedge clk) begin
		in_took = arst_n && in_valid && in_ready;
		if (in_took)
			render_item('{op, char_code, normal_video, start_page, start_column,
				store_addr, store_byte});
	end

	// Sender: present the next item once the previous one is gone
	always @(negedge clk) begin
		text_item_t it;
		if (!in_valid || in_took) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_items.pop_front();
				op           <= it.op;
				char_code    <= it.code;
				normal_video <= it.normal;
				start_page   <= it.page;
				start_column <= it.col;
				store_addr   <= it.addr;
				store_byte   <= it.data;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or one long hold-off on request
	always @(negedge clk) begin
		if (stall_req && !stall_done) begin
			out_ready <= 1'b0;
			stall_cycles++;
			if (stall_cycles >= LONG_STALL)
				stall_done = 1'b1;
		end else begin
			if (!stall_req) begin
				stall_cycles = 0;
				stall_done   = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Output side: compare each column write with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_writes.size() == 0) begin
				$error("column write with none expected: page %0d column %0d pixels %0h",
					page, column, pixels);
				mismatches++;
			end else begin
				want_wr = expected_writes.pop_front();
				check_field("right_half", 8'(want_wr.right_half), 8'(right_half));
				check_field("page", 8'(want_wr.page), 8'(page));
				check_field("column", 8'(want_wr.column), 8'(column));
				check_field("pixels", want_wr.pixels, pixels);
				check_field("last", 8'(want_wr.last), 8'(last));
			end
		end
	end

	// Watchdog: no progress while work is outstanding
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)
				|| (pending_items.size() == 0 && !in_valid && expected_writes.size() == 0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("text_column_renderer regression: fail");
			$finish;
		end
	end

	initial begin
		reg_width = 4'd5;
		reg_gap   = 3'd0;
		reg_first = 8'd32;
		cur_page  = 3'd0;
		cur_col   = 8'd0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed items at reset settings
		send_idle_pct = 38;
		recv_idle_pct = 76;
		queue_load(9'd0, 8'h00);
		queue_load(9'd1, 8'hFF);
		queue_load(9'd2, 8'h01);
		queue_load(9'd3, 8'h80);
		queue_load(9'd4, 8'h5A);
		queue_print(tcr_pkg::OP_PRINT, 8'd32, 1'b1, 3'd0, 7'd0);
		queue_print(tcr_pkg::OP_PRINT, 8'd32, 1'b0, 3'd7, 7'd127);
		// Glyph straddles the two halves
		queue_print(tcr_pkg::OP_PRINT_AT, 8'd32, 1'b1, 3'd0, 7'd60);
		// Latest start that does not wrap: the glyph ends just before the last column
		queue_print(tcr_pkg::OP_PRINT_AT, 8'd32, 1'b1, 3'd3, 7'd122);
		// Inverted wrap: fill the rest of the row, then next page
		queue_print(tcr_pkg::OP_PRINT, 8'd32, 1'b0, 3'd0, 7'd0);
		// Wrap from the last page back to page 0, glyph reaching the top font entry
		queue_print(tcr_pkg::OP_PRINT_AT, 8'd134, 1'b0, 3'd7, 7'd127);
		queue_print(tcr_pkg::OP_PRINT_AT, 8'd0, 1'b1, 3'd5, 7'd123);
		// Code below the first glyph: offset wraps around
		queue_print(tcr_pkg::OP_PRINT_AT, 8'd31, 1'b1, 3'd0, 7'd0);
		queue_item(OP_UNUSED, 8'hFF, 1'b1, 3'd7, 7'd127, 9'd511, 8'hFF);
		drain();

		// Widest glyph, widest gap: off-panel gap columns
		write_reg(tcr_pkg::REG_GLYPH_WIDTH, 8'd8);
		write_reg(tcr_pkg::REG_GLYPH_GAP, 8'd7);
		write_reg(tcr_pkg::REG_FIRST_CODE, 8'd0);
		random_items(70);
		drain();

		// Narrowest glyph, with a long receiver hold-off
		send_idle_pct = 76;
		recv_idle_pct = 38;
		write_reg(tcr_pkg::REG_GLYPH_WIDTH, 8'd1);
		write_reg(tcr_pkg::REG_GLYPH_GAP, 8'd3);
		write_reg(tcr_pkg::REG_FIRST_CODE, 8'd255);
		stall_req = 1'b1;
		random_items(70);
		wait (stall_done);
		stall_req = 1'b0;
		drain();

		// Zero width: only gap columns remain
		write_reg(tcr_pkg::REG_GLYPH_WIDTH, 8'd0);
		write_reg(tcr_pkg::REG_GLYPH_GAP, 8'd5);
		write_reg(tcr_pkg::REG_FIRST_CODE, 8'($urandom_range(255)));
		random_items(30);
		drain();

		// Width above range, unused register index, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(tcr_pkg::REG_GLYPH_WIDTH, 8'hFF);
		write_reg(tcr_pkg::REG_GLYPH_GAP, 8'hF9);
		write_reg(tcr_pkg::REG_FIRST_CODE, 8'($urandom_range(255)));
		write_reg(REG_NONE, 8'($urandom_range(255)));
		random_items(75);
		drain();

		if (mismatches == 0 && expected_writes.size() == 0)
			$display("text_column_renderer regression: pass");
		else
			$display("text_column_renderer regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

>>> text_column_renderer.f
rtl/core/tcr_pkg.sv
rtl/core/tcr_ram.sv
rtl/core/tcr_emit.sv
rtl/core/tcr_seq.sv
rtl/core/text_column_renderer.sv
rtl/core/tcr_checker.sv
sim/text_column_renderer_tb.sv
